// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Simulation builds get the checks;
// synthesis builds define SYNTH and the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RST(name, clk, rst, prop)
`define ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== rtl/core/ifp_pkg.sv =====
package ifp_pkg;

  // Operator stack depth (number of cells in the chain)
  localparam int STACK_DEPTH = 32;

  // ASCII characters the converter reacts to
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // Stacked operator codes
  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_code_t;

  // One stack entry; occ marks an occupied cell (occupancy is a thermometer)
  typedef struct packed {
    logic     occ;
    op_code_t code;
  } stk_ent_t;

  // Shared command broadcast to every cell
  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stk_ctl_t;

  // What the control logic sees of the stack
  typedef struct packed {
    logic     top_occ;
    op_code_t top_code;
    logic     full;
  } stk_view_t;

  // Map an operator code back to its ASCII character
  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] ch;
    case (code)
      OP_OPEN: ch = CH_OPEN;
      OP_ADD:  ch = CH_PLUS;
      OP_SUB:  ch = CH_MINUS;
      OP_MUL:  ch = CH_STAR;
      OP_DIV:  ch = CH_SLASH;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/ifp_cell.sv =====
module ifp_cell (
  input  logic              clk,
  input  logic              rst,
  input  ifp_pkg::stk_ctl_t ctl,
  input  ifp_pkg::stk_ent_t from_up,
  input  ifp_pkg::stk_ent_t from_down,
  output ifp_pkg::stk_ent_t ent
);
  import ifp_pkg::*;

  // Occupancy: shift down on push, up on pop
  // Operator code follows the same moves, no reset needed
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.occ <= 1'b0;
    end else if (ctl.push) begin
      ent.occ <= from_up.occ;
    end else if (ctl.pop) begin
      ent.occ <= from_down.occ;
    end
    if (ctl.push) begin
      ent.code <= from_up.code;
    end else if (ctl.pop) begin
      ent.code <= from_down.code;
    end
  end

endmodule

// ===== rtl/core/ifp_stack.sv =====
module ifp_stack (
  input  logic               clk,
  input  logic               rst,
  input  ifp_pkg::stk_ctl_t  ctl,
  output ifp_pkg::stk_view_t view
);
  import ifp_pkg::*;

  stk_ent_t ent [STACK_DEPTH];

  // Chain of cells, cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    stk_ent_t up_ent;
    stk_ent_t down_ent;

    if (i == 0) begin : g_top
      assign up_ent = '{occ: 1'b1, code: ctl.code};
    end else begin : g_mid_up
      assign up_ent = ent[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down_ent = '{occ: 1'b0, code: OP_OPEN};
    end else begin : g_mid_down
      assign down_ent = ent[i+1];
    end

    ifp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .from_up   (up_ent),
      .from_down (down_ent),
      .ent       (ent[i])
    );
  end

  // Expose top entry and full flag
  assign view.top_occ  = ent[0].occ;
  assign view.top_code = ent[0].code;
  assign view.full     = ent[STACK_DEPTH-1].occ;

endmodule

// ===== rtl/core/infix_to_postfix_converter_top.sv =====
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata = symbol, s_tlast = end_of_expression
// m_*      out  m_tvalid/m_tready   m_tdata = out_symbol, m_tlast = last_of_run,
//                                   m_tuser = has_symbol, expression_done, error
//
// One character is worked on at a time. A word is loaded, then entries are popped
// off the cell chain one by one as precedence requires, then the operator is pushed
// or the letter is emitted; an end word then flushes the rest of the stack, and a
// closing step finishes the character. Every working cycle waits while the
// output register is full and not taken.
// Reset (rst, synchronous) empties the stack and the error flag.
`include "assert_macros.svh"

module infix_to_postfix_converter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic       s_tlast,   // end_of_expression
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_symbol
  output logic       m_tlast,   // last_of_run
  output logic [2:0] m_tuser    // [0] has_symbol, [1] expression_done, [2] error
);
  import ifp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAR,
    ST_FLUSH,
    ST_FINAL
  } state_t;

  typedef enum logic [2:0] {
    CL_LETTER,
    CL_ADDSUB,
    CL_MULDIV,
    CL_OPEN,
    CL_CLOSE,
    CL_OTHER
  } cls_t;

  state_t     state;
  state_t     state_next;
  cls_t       cls;
  cls_t       cls_in;
  logic [7:0] sym;
  logic       eoe;
  logic       error_seen;
  logic       hold_valid;
  logic [7:0] hold_sym;

  stk_ctl_t   ctl;
  stk_view_t  view;

  logic       slot_free;
  logic       go;
  logic       accept;
  logic       emit_en;
  logic [7:0] emit_sym;
  logic       err_set;
  logic       fin;
  logic       load_out;
  op_code_t   push_code;
  state_t     after_char;

  ifp_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .view (view)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign go        = slot_free && (state != ST_IDLE);

  // Classify the incoming word
  always_comb begin
    if (s_tdata inside {[CH_A:CH_Z]}) begin
      cls_in = CL_LETTER;
    end else if (s_tdata == CH_PLUS || s_tdata == CH_MINUS) begin
      cls_in = CL_ADDSUB;
    end else if (s_tdata == CH_STAR || s_tdata == CH_SLASH) begin
      cls_in = CL_MULDIV;
    end else if (s_tdata == CH_OPEN) begin
      cls_in = CL_OPEN;
    end else if (s_tdata == CH_CLOSE) begin
      cls_in = CL_CLOSE;
    end else begin
      cls_in = CL_OTHER;
    end
  end

  // Operator code pushed for the held character
  always_comb begin
    case (sym)
      CH_PLUS:  push_code = OP_ADD;
      CH_MINUS: push_code = OP_SUB;
      CH_STAR:  push_code = OP_MUL;
      CH_SLASH: push_code = OP_DIV;
      default:  push_code = OP_OPEN;
    endcase
  end

  assign after_char = eoe ? ST_FLUSH : ST_FINAL;

  // Decide this cycle's stack move and emitted symbol
  always_comb begin
    state_next = state;
    ctl        = '{push: 1'b0, pop: 1'b0, code: push_code};
    emit_en    = 1'b0;
    emit_sym   = op_char(view.top_code);
    err_set    = 1'b0;
    fin        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CHAR;
      end
      ST_CHAR: begin
        if (go) begin
          case (cls)
            CL_LETTER: begin
              emit_en    = 1'b1;
              emit_sym   = sym;
              state_next = after_char;
            end
            CL_ADDSUB, CL_MULDIV, CL_OPEN: begin
              if (cls != CL_OPEN && view.top_occ &&
                  ((cls == CL_ADDSUB && view.top_code != OP_OPEN) ||
                   (cls == CL_MULDIV &&
                    (view.top_code == OP_MUL || view.top_code == OP_DIV)))) begin
                ctl.pop = 1'b1;
                emit_en = 1'b1;
              end else begin
                // drop the push on a full stack
                if (view.full) err_set = 1'b1;
                else           ctl.push = 1'b1;
                state_next = after_char;
              end
            end
            CL_CLOSE: begin
              if (view.top_occ && view.top_code != OP_OPEN) begin
                ctl.pop = 1'b1;
                emit_en = 1'b1;
              end else begin
                // discard the matching open paren, or flag an unmatched close
                if (view.top_occ) ctl.pop = 1'b1;
                else              err_set = 1'b1;
                state_next = after_char;
              end
            end
            default: state_next = after_char;
          endcase
        end
      end
      ST_FLUSH: begin
        if (go) begin
          if (view.top_occ) begin
            ctl.pop = 1'b1;
            emit_en = (view.top_code != OP_OPEN);
          end else begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (go) begin
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Load the output register when a held symbol is released or the run closes
  assign load_out = (emit_en && hold_valid) || (fin && (hold_valid || eoe));

  // State, held result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      hold_valid <= 1'b0;
      error_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      if (accept) begin
        sym <= s_tdata;
        eoe <= s_tlast;
        cls <= cls_in;
      end

      if (err_set) error_seen <= 1'b1;

      // Release the previous symbol once another one follows it
      if (emit_en) begin
        if (hold_valid) begin
          m_tdata  <= hold_sym;
          m_tlast  <= 1'b0;
          m_tuser  <= 3'b001;
        end
        hold_valid <= 1'b1;
        hold_sym   <= emit_sym;
      end

      // Close the run: last symbol, or a bare end marker
      if (fin) begin
        if (hold_valid || eoe) begin
          m_tdata  <= hold_valid ? hold_sym : 8'h00;
          m_tlast  <= 1'b1;
          m_tuser  <= {eoe & error_seen, eoe, hold_valid};
        end
        hold_valid <= 1'b0;
        if (eoe) error_seen <= 1'b0;
      end
    end
  end

  // Held symbol is always released before the next word is taken
  `ASSERT_RST(a_idle_hold_empty, clk, rst, s_tready |-> !hold_valid)
  // One word at a time: ready drops after an accept
  `ASSERT_RST(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready)
  // Expression end always closes the run
  `ASSERT_RST(a_done_is_last, clk, rst, (m_tvalid && m_tuser[1]) |-> m_tlast)
  // Error is only reported with the end of the expression
  `ASSERT_RST(a_err_on_done, clk, rst, (m_tvalid && m_tuser[2]) |-> m_tuser[1])

endmodule
